[sv/pfpm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pfpm_pkg;

    localparam int PAGE_W = 31;
    localparam int OUT_FRAME_W = 4;

    localparam logic [2:0] OP_FETCH     = 3'd0;
    localparam logic [2:0] OP_UNPIN     = 3'd1;
    localparam logic [2:0] OP_FLUSH     = 3'd2;
    localparam logic [2:0] OP_NEW       = 3'd3;
    localparam logic [2:0] OP_DELETE    = 3'd4;
    localparam logic [2:0] OP_FLUSH_ALL = 3'd5;

    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_READ    = 3'd1;
    localparam logic [2:0] CMD_WRITE   = 3'd2;
    localparam logic [2:0] CMD_DEALLOC = 3'd3;
    localparam logic [2:0] CMD_ZERO    = 3'd4;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NOT_RESIDENT = 3'd1;
    localparam logic [2:0] ST_ALL_PINNED   = 3'd2;
    localparam logic [2:0] ST_PINNED       = 3'd3;
    localparam logic [2:0] ST_PIN_ZERO     = 3'd4;

    typedef enum logic [1:0] {
        PS_REQ   = 2'd0,
        PS_ALLOC = 2'd1,
        PS_SEL   = 2'd2,
        PS_PEND  = 2'd3
    } page_src_t;

    typedef enum logic [1:0] {
        FS_ZERO = 2'd0,
        FS_SEL  = 2'd1,
        FS_PEND = 2'd2
    } frame_src_t;

    typedef enum logic [2:0] {
        A_NONE      = 3'd0,
        A_PIN_INC   = 3'd1,
        A_UNPIN     = 3'd2,
        A_TAKE_FREE = 3'd3,
        A_TAKE_LRU  = 3'd4,
        A_INSTALL   = 3'd5,
        A_DELETE    = 3'd6
    } act_t;

    typedef struct packed {
        logic [2:0] cmd;
        page_src_t  psrc;
        frame_src_t fsrc;
        logic [2:0] status;
        logic       last;
    } emit_t;

    typedef struct packed {
        logic  accept;
        logic  scan_step;
        logic  walk_step;
        act_t  act;
        logic  rm_start;
        logic  rm_step;
        logic  emit;
        emit_t desc;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       match;
        logic       scan_last;
        logic       hit;
        logic       pins_zero;
        logic       free_avail;
        logic       lru_avail;
        logic       victim_dirty;
        logic       rm_done;
        logic       walk_done;
        logic       cur_valid;
        logic       pend_valid;
        logic       out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

[sv/pfpm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module pfpm_ctrl
    import pfpm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [2:0] opcode,
    output logic            in_ready,
    input  wire dp_stat_t   stat,
    output dp_cmd_t         cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SCAN    = 9'b000000010,
        S_DECIDE  = 9'b000000100,
        S_TAKE    = 9'b000001000,
        S_WBACK   = 9'b000010000,
        S_INSTALL = 9'b000100000,
        S_RM      = 9'b001000000,
        S_EMIT    = 9'b010000000,
        S_WALK    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    emit_t  emit_reg, emit_next;

    function automatic emit_t mk(input logic [2:0] c, input page_src_t p,
                                 input frame_src_t f, input logic [2:0] s,
                                 input logic l);
        emit_t e;
        e.cmd = c;
        e.psrc = p;
        e.fsrc = f;
        e.status = s;
        e.last = l;
        return e;
    endfunction

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        emit_next = emit_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    case (opcode)
                        OP_FETCH, OP_UNPIN, OP_FLUSH, OP_DELETE: state_next = S_SCAN;
                        OP_NEW: state_next = S_TAKE;
                        OP_FLUSH_ALL: state_next = S_WALK;
                        default:
                        begin
                            emit_next = mk(CMD_NONE, PS_REQ, FS_ZERO, ST_OK, 1'b1);
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.match || stat.scan_last)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_EMIT;
                case (stat.op)
                    OP_FETCH:
                    begin
                        if (stat.hit)
                        begin
                            cmd.act = A_PIN_INC;
                            cmd.rm_start = 1'b1;
                            emit_next = mk(CMD_NONE, PS_REQ, FS_SEL, ST_OK, 1'b1);
                            state_next = S_RM;
                        end
                        else
                            state_next = S_TAKE;
                    end
                    OP_UNPIN:
                    begin
                        if (!stat.hit)
                            emit_next = mk(CMD_NONE, PS_REQ, FS_ZERO, ST_NOT_RESIDENT, 1'b1);
                        else if (stat.pins_zero)
                            emit_next = mk(CMD_NONE, PS_REQ, FS_SEL, ST_PIN_ZERO, 1'b1);
                        else
                        begin
                            cmd.act = A_UNPIN;
                            emit_next = mk(CMD_NONE, PS_REQ, FS_SEL, ST_OK, 1'b1);
                        end
                    end
                    OP_FLUSH:
                    begin
                        if (!stat.hit)
                            emit_next = mk(CMD_NONE, PS_REQ, FS_ZERO, ST_NOT_RESIDENT, 1'b1);
                        else
                            emit_next = mk(CMD_WRITE, PS_REQ, FS_SEL, ST_OK, 1'b1);
                    end
                    OP_DELETE:
                    begin
                        if (!stat.hit)
                            emit_next = mk(CMD_DEALLOC, PS_REQ, FS_ZERO, ST_OK, 1'b1);
                        else if (!stat.pins_zero)
                            emit_next = mk(CMD_NONE, PS_REQ, FS_SEL, ST_PINNED, 1'b1);
                        else
                        begin
                            cmd.act = A_DELETE;
                            cmd.rm_start = 1'b1;
                            emit_next = mk(CMD_DEALLOC, PS_REQ, FS_SEL, ST_OK, 1'b1);
                            state_next = S_RM;
                        end
                    end
                    default: emit_next = mk(CMD_NONE, PS_REQ, FS_ZERO, ST_OK, 1'b1);
                endcase
            end
            S_TAKE:
            begin
                if (stat.free_avail)
                begin
                    cmd.act = A_TAKE_FREE;
                    state_next = S_INSTALL;
                end
                else if (stat.lru_avail)
                begin
                    cmd.act = A_TAKE_LRU;
                    state_next = stat.victim_dirty ? S_WBACK : S_INSTALL;
                end
                else
                begin
                    if (stat.op == OP_NEW)
                        emit_next = mk(CMD_DEALLOC, PS_ALLOC, FS_ZERO, ST_ALL_PINNED, 1'b1);
                    else
                        emit_next = mk(CMD_NONE, PS_REQ, FS_ZERO, ST_ALL_PINNED, 1'b1);
                    state_next = S_EMIT;
                end
            end
            S_WBACK:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.desc = mk(CMD_WRITE, PS_SEL, FS_SEL, ST_OK, 1'b0);
                    state_next = S_INSTALL;
                end
            end
            S_INSTALL:
            begin
                cmd.act = A_INSTALL;
                cmd.rm_start = 1'b1;
                if (stat.op == OP_NEW)
                    emit_next = mk(CMD_ZERO, PS_ALLOC, FS_SEL, ST_OK, 1'b1);
                else
                    emit_next = mk(CMD_READ, PS_REQ, FS_SEL, ST_OK, 1'b1);
                state_next = S_RM;
            end
            S_RM:
            begin
                cmd.rm_step = 1'b1;
                if (stat.rm_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.desc = emit_reg;
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (stat.walk_done)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit = 1'b1;
                        if (stat.pend_valid)
                            cmd.desc = mk(CMD_WRITE, PS_PEND, FS_PEND, ST_OK, 1'b1);
                        else
                            cmd.desc = mk(CMD_NONE, PS_REQ, FS_ZERO, ST_OK, 1'b1);
                        state_next = S_IDLE;
                    end
                end
                else if (stat.cur_valid && stat.pend_valid)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit = 1'b1;
                        cmd.desc = mk(CMD_WRITE, PS_PEND, FS_PEND, ST_OK, 1'b0);
                        cmd.walk_step = 1'b1;
                    end
                end
                else
                    cmd.walk_step = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            emit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            emit_reg <= emit_next;
        end
    end

endmodule
`default_nettype wire

[sv/pfpm_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module pfpm_dp
    import pfpm_pkg::*;
#(
    parameter int POOL_FRAMES = 16,
    parameter int PIN_BITS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_cmd_t           cmd,
    output dp_stat_t               stat,
    input  wire logic [2:0]        opcode,
    input  wire logic [PAGE_W-1:0] page_number,
    input  wire logic              mark_dirty,
    input  wire logic [PAGE_W-1:0] allocated_page,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [2:0]             storage_cmd,
    output logic [PAGE_W-1:0]      storage_page,
    output logic [OUT_FRAME_W-1:0] frame_index,
    output logic [2:0]             status,
    output logic                   last
);

    localparam int FW = $clog2(POOL_FRAMES);
    localparam int CW = $clog2(POOL_FRAMES + 1);
    localparam int CW1 = CW + 1;

    logic [2:0]          op_reg;
    logic [PAGE_W-1:0]   rpage_reg;
    logic                rdirty_reg;
    logic [PAGE_W-1:0]   ralloc_reg;

    logic [CW-1:0]       idx_reg;
    logic                hit_reg;
    logic [FW-1:0]       sel_reg;
    logic [FW-1:0]       pend_reg;
    logic                pend_v_reg;

    logic [PAGE_W-1:0]   page_reg [POOL_FRAMES];
    logic                valid_reg [POOL_FRAMES];
    logic [PIN_BITS-1:0] pins_reg [POOL_FRAMES];
    logic                dirty_reg [POOL_FRAMES];
    logic [FW-1:0]       fq_reg [POOL_FRAMES];
    logic [FW-1:0]       fhead_reg;
    logic [CW-1:0]       fcnt_reg;
    logic [FW-1:0]       lru_reg [POOL_FRAMES];
    logic [CW-1:0]       lcnt_reg;
    logic [CW-1:0]       rj_reg;
    logic [CW-1:0]       rw_reg;
    logic                rfound_reg;

    logic [FW-1:0]       idx_f;
    logic [CW1-1:0]      tail_sum;
    logic [FW-1:0]       ftail;
    logic [FW-1:0]       fhead_next;
    logic [FW-1:0]       victim;
    logic [FW-1:0]       rm_elem;
    logic [PAGE_W-1:0]   emit_page;
    logic [FW-1:0]       emit_frame;

    assign idx_f = idx_reg[FW-1:0];
    assign tail_sum = CW1'(fhead_reg) + CW1'(fcnt_reg);
    assign ftail = (tail_sum >= CW1'(POOL_FRAMES)) ? FW'(tail_sum - CW1'(POOL_FRAMES))
                                                   : FW'(tail_sum);
    assign fhead_next = (fhead_reg == FW'(POOL_FRAMES - 1)) ? '0 : fhead_reg + 1'b1;
    assign victim = lru_reg[0];
    assign rm_elem = lru_reg[rj_reg[FW-1:0]];

    always_comb
    begin
        stat.op = op_reg;
        stat.match = valid_reg[idx_f] && (page_reg[idx_f] == rpage_reg);
        stat.scan_last = (idx_reg == CW'(POOL_FRAMES - 1));
        stat.hit = hit_reg;
        stat.pins_zero = (pins_reg[sel_reg] == '0);
        stat.free_avail = (fcnt_reg != '0);
        stat.lru_avail = (lcnt_reg != '0);
        stat.victim_dirty = valid_reg[victim] && dirty_reg[victim];
        stat.rm_done = (rj_reg == lcnt_reg);
        stat.walk_done = (idx_reg == CW'(POOL_FRAMES));
        stat.cur_valid = valid_reg[idx_f];
        stat.pend_valid = pend_v_reg;
        stat.out_free = !out_valid || out_ready;
    end

    always_comb
    begin
        case (cmd.desc.psrc)
            PS_REQ:   emit_page = rpage_reg;
            PS_ALLOC: emit_page = ralloc_reg;
            PS_SEL:   emit_page = page_reg[sel_reg];
            PS_PEND:  emit_page = page_reg[pend_reg];
            default:  emit_page = '0;
        endcase
        case (cmd.desc.fsrc)
            FS_SEL:  emit_frame = sel_reg;
            FS_PEND: emit_frame = pend_reg;
            default: emit_frame = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.emit)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            storage_cmd <= cmd.desc.cmd;
            storage_page <= (cmd.desc.cmd == CMD_NONE) ? '0 : emit_page;
            frame_index <= OUT_FRAME_W'(emit_frame);
            status <= cmd.desc.status;
            last <= cmd.desc.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg <= opcode;
            rpage_reg <= page_number;
            rdirty_reg <= mark_dirty;
            ralloc_reg <= allocated_page;
        end
        if (cmd.act == A_INSTALL)
            page_reg[sel_reg] <= (op_reg == OP_NEW) ? ralloc_reg : rpage_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            hit_reg <= 1'b0;
            sel_reg <= '0;
            pend_reg <= '0;
            pend_v_reg <= 1'b0;
            fhead_reg <= '0;
            fcnt_reg <= CW'(POOL_FRAMES);
            lcnt_reg <= '0;
            rj_reg <= '0;
            rw_reg <= '0;
            rfound_reg <= 1'b0;
            for (int i = 0; i < POOL_FRAMES; i++)
            begin
                valid_reg[i] <= 1'b0;
                pins_reg[i] <= '0;
                dirty_reg[i] <= 1'b0;
                fq_reg[i] <= FW'(i);
                lru_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.accept)
            begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
                pend_v_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                if (stat.match)
                begin
                    hit_reg <= 1'b1;
                    sel_reg <= idx_f;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.walk_step)
            begin
                if (stat.cur_valid)
                begin
                    pend_reg <= idx_f;
                    pend_v_reg <= 1'b1;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            case (cmd.act)
                A_PIN_INC:
                begin
                    if (!(&pins_reg[sel_reg]))
                        pins_reg[sel_reg] <= pins_reg[sel_reg] + 1'b1;
                end
                A_UNPIN:
                begin
                    pins_reg[sel_reg] <= pins_reg[sel_reg] - 1'b1;
                    if (pins_reg[sel_reg] == PIN_BITS'(1) && lcnt_reg < CW'(POOL_FRAMES))
                    begin
                        lru_reg[lcnt_reg[FW-1:0]] <= sel_reg;
                        lcnt_reg <= lcnt_reg + 1'b1;
                    end
                    if (rdirty_reg)
                        dirty_reg[sel_reg] <= 1'b1;
                end
                A_TAKE_FREE:
                begin
                    sel_reg <= fq_reg[fhead_reg];
                    fhead_reg <= fhead_next;
                    fcnt_reg <= fcnt_reg - 1'b1;
                end
                A_TAKE_LRU: sel_reg <= victim;
                A_INSTALL:
                begin
                    valid_reg[sel_reg] <= 1'b1;
                    pins_reg[sel_reg] <= PIN_BITS'(1);
                    dirty_reg[sel_reg] <= 1'b0;
                end
                A_DELETE:
                begin
                    valid_reg[sel_reg] <= 1'b0;
                    pins_reg[sel_reg] <= '0;
                    dirty_reg[sel_reg] <= 1'b0;
                    if (fcnt_reg < CW'(POOL_FRAMES))
                    begin
                        fq_reg[ftail] <= sel_reg;
                        fcnt_reg <= fcnt_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if (cmd.rm_start)
            begin
                rj_reg <= '0;
                rw_reg <= '0;
                rfound_reg <= 1'b0;
            end
            if (cmd.rm_step)
            begin
                if (rj_reg < lcnt_reg)
                begin
                    if (rm_elem == sel_reg && !rfound_reg)
                        rfound_reg <= 1'b1;
                    else
                    begin
                        lru_reg[rw_reg[FW-1:0]] <= rm_elem;
                        rw_reg <= rw_reg + 1'b1;
                    end
                    rj_reg <= rj_reg + 1'b1;
                end
                else if (rfound_reg)
                    lcnt_reg <= lcnt_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[sv/page_frame_pool_manager_top.sv]
// Lookup requests (fetch, unpin, flush, delete) scan the frames one per cycle, stopping at a match;
// fetch hits, deletes of unpinned pages and every install then walk the LRU order to compact it.
// One request is taken at a time; flush all walks every frame and waits on output stalls.
// The frame scan counter and the LRU compaction walk set how long a request takes.
// Reset (rst_n, async low): all frames invalid and unpinned, free queue holds every
// frame in order, LRU order empty, no result pending.
`timescale 1ns / 1ps
`default_nettype none
module page_frame_pool_manager_top
    import pfpm_pkg::*;
#(
    parameter int POOL_FRAMES = 16,
    parameter int PIN_BITS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [2:0]        opcode,
    input  wire logic [PAGE_W-1:0] page_number,
    input  wire logic              mark_dirty,
    input  wire logic [PAGE_W-1:0] allocated_page,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [2:0]             storage_cmd,
    output logic [PAGE_W-1:0]      storage_page,
    output logic [OUT_FRAME_W-1:0] frame_index,
    output logic [2:0]             status,
    output logic                   last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pfpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfpm_dp #(
        .POOL_FRAMES (POOL_FRAMES),
        .PIN_BITS    (PIN_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (opcode),
        .page_number    (page_number),
        .mark_dirty     (mark_dirty),
        .allocated_page (allocated_page),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .storage_cmd    (storage_cmd),
        .storage_page   (storage_page),
        .frame_index    (frame_index),
        .status         (status),
        .last           (last)
    );

`ifndef NO_ASSERTIONS
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("new request taken while one is in progress");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result loaded over an undelivered result");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> last)
        else $error("error status on a non-final result");

    a_idle_no_act: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (cmd.act == A_NONE && !cmd.rm_step && !cmd.scan_step))
        else $error("datapath action while idle");
`endif

endmodule
`default_nettype wire
